FILE: rtl/tcpf_pkg.sv
`timescale 1ns / 1ps

package tcpf_pkg;

	localparam int DEPTH        = 16;
	localparam int PAYLOAD_BITS = 50;
	localparam int PTR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W       = $clog2(DEPTH + 1);
	localparam int LVL_W        = 5;
	localparam int OP_W         = 2;
	localparam int STS_W        = 2;

	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_PROMOTE = 2'd2;

	localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY   = 2'd2;
	localparam logic [STS_W-1:0] STS_NOTHING = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic                    push_urgent;
		logic [PAYLOAD_BITS-1:0] push_payload;
	} in_t;

	typedef struct packed {
		logic [STS_W-1:0]        status;
		logic [PAYLOAD_BITS-1:0] pop_payload;
		logic                    pop_from_urgent;
		logic [LVL_W-1:0]        normal_level;
		logic [LVL_W-1:0]        urgent_level;
	} out_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

FILE: rtl/tcpf_ctrl.sv
`timescale 1ns / 1ps

module tcpf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tcpf_pkg::stat_t stat,
	output tcpf_pkg::cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_valid && in_ready;
		cmd.exec = (state_q == ST_EXEC) && !stat.out_busy;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.exec) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/tcpf_dp.sv
`timescale 1ns / 1ps

module tcpf_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  tcpf_pkg::in_t   in_data,
	input  tcpf_pkg::cmd_t  cmd,
	output tcpf_pkg::stat_t stat,
	output logic            out_valid,
	input  logic            out_ready,
	output tcpf_pkg::out_t  out_data
);

	logic [tcpf_pkg::PAYLOAD_BITS-1:0] n_mem [tcpf_pkg::DEPTH];
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] u_mem [tcpf_pkg::DEPTH];
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] n_rd_q;
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] u_rd_q;

	tcpf_pkg::in_t               item_q;
	tcpf_pkg::out_t              out_q;
	logic                        out_valid_q;
	logic [tcpf_pkg::PTR_W-1:0]  n_rp_q, n_wp_q, u_rp_q, u_wp_q;
	logic [tcpf_pkg::FILL_W-1:0] n_fill_q, u_fill_q, n_fill_d, u_fill_d;
	logic [tcpf_pkg::FILL_W:0]   total;

	logic                              n_take, n_put, u_take, u_put, from_u;
	logic [tcpf_pkg::STS_W-1:0]        sts;
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] popped, u_wdata;

	function automatic logic [tcpf_pkg::PTR_W-1:0] ptr_next(
		input logic [tcpf_pkg::PTR_W-1:0] p
	);
		if (p == tcpf_pkg::PTR_W'(tcpf_pkg::DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign total = (tcpf_pkg::FILL_W + 1)'(n_fill_q) + (tcpf_pkg::FILL_W + 1)'(u_fill_q);

	always_comb begin
		n_take = 1'b0;
		n_put  = 1'b0;
		u_take = 1'b0;
		u_put  = 1'b0;
		from_u = 1'b0;
		sts    = tcpf_pkg::STS_DONE;
		popped = '0;
		case (item_q.operation)
			tcpf_pkg::OP_PUSH: begin
				if (total >= (tcpf_pkg::FILL_W + 1)'(tcpf_pkg::DEPTH)) begin
					sts = tcpf_pkg::STS_FULL;
				end else if (item_q.push_urgent) begin
					u_put = 1'b1;
				end else begin
					n_put = 1'b1;
				end
			end
			tcpf_pkg::OP_POP: begin
				if (u_fill_q != '0) begin
					u_take = 1'b1;
					from_u = 1'b1;
					popped = u_rd_q;
				end else if (n_fill_q != '0) begin
					n_take = 1'b1;
					popped = n_rd_q;
				end else begin
					sts = tcpf_pkg::STS_EMPTY;
				end
			end
			tcpf_pkg::OP_PROMOTE: begin
				if (n_fill_q != '0) begin
					n_take = 1'b1;
					u_put  = 1'b1;
				end else begin
					sts = tcpf_pkg::STS_NOTHING;
				end
			end
			default: begin
			end
		endcase
		u_wdata  = (item_q.operation == tcpf_pkg::OP_PROMOTE) ? n_rd_q : item_q.push_payload;
		n_fill_d = n_fill_q + tcpf_pkg::FILL_W'(n_put) - tcpf_pkg::FILL_W'(n_take);
		u_fill_d = u_fill_q + tcpf_pkg::FILL_W'(u_put) - tcpf_pkg::FILL_W'(u_take);
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && n_put) begin
			n_mem[n_wp_q] <= item_q.push_payload;
		end
		if (cmd.exec && u_put) begin
			u_mem[u_wp_q] <= u_wdata;
		end
		n_rd_q <= n_mem[n_rp_q];
		u_rd_q <= u_mem[u_rp_q];
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			out_q.status          <= sts;
			out_q.pop_payload     <= popped;
			out_q.pop_from_urgent <= from_u;
			out_q.normal_level    <= tcpf_pkg::LVL_W'(n_fill_d);
			out_q.urgent_level    <= tcpf_pkg::LVL_W'(u_fill_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_rp_q      <= '0;
			n_wp_q      <= '0;
			u_rp_q      <= '0;
			u_wp_q      <= '0;
			n_fill_q    <= '0;
			u_fill_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (n_take) begin
					n_rp_q <= ptr_next(n_rp_q);
				end
				if (n_put) begin
					n_wp_q <= ptr_next(n_wp_q);
				end
				if (u_take) begin
					u_rp_q <= ptr_next(u_rp_q);
				end
				if (u_put) begin
					u_wp_q <= ptr_next(u_wp_q);
				end
				n_fill_q    <= n_fill_d;
				u_fill_q    <= u_fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	// The two queues together never hold more than the shared capacity.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		total <= (tcpf_pkg::FILL_W + 1)'(tcpf_pkg::DEPTH))
		else $error("queues exceed shared capacity");

	// An empty normal queue has its read and write pointers together.
	a_normal_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(n_fill_q == '0) |-> (n_rp_q == n_wp_q))
		else $error("normal queue pointers disagree with its fill");

	// A promote moves an entry between queues and keeps the total.
	a_promote_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && item_q.operation == tcpf_pkg::OP_PROMOTE) |=> (total == $past(total)))
		else $error("promote changed the total fill");

	// A result is only produced when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("result overwrote an untaken result");

endmodule

FILE: rtl/two_class_priority_fifo_with_promotion.sv
`timescale 1ns / 1ps
// An operation is registered when transferred in; its result is registered when it executes.
// The controller alternates accept and execute; execution waits while a result sits untaken.
// The next operation may be transferred while the previous result waits on the output.
// Reset clears pointers, fill counts and the controller; queue storage is not cleared.

module two_class_priority_fifo_with_promotion (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tcpf_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tcpf_pkg::out_t out_data
);

	tcpf_pkg::cmd_t  cmd;
	tcpf_pkg::stat_t stat;

	tcpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcpf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: sim/two_class_priority_fifo_with_promotion_tb.sv
`timescale 1ns / 1ps

module two_class_priority_fifo_with_promotion_tb;

	localparam logic [tcpf_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 2000;
	localparam int TAIL_ITEMS   = 200;
	localparam int MAX_REPORTS  = 100;
	localparam int SETTLE       = 8;

	typedef struct {
		tcpf_pkg::in_t op;
		bit            wait_drain;
	} pending_op_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	tcpf_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	tcpf_pkg::out_t out_data;

	pending_op_t                       op_backlog[$];
	pending_op_t                       next_op;
	tcpf_pkg::out_t                    due_results[$];
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] normal_tasks[$];
	logic [tcpf_pkg::PAYLOAD_BITS-1:0] urgent_tasks[$];
	int                                mismatches   = 0;
	int                                results_seen = 0;
	int                                send_gap     = 0;
	int                                recv_stall   = 0;
	bit                                quiet_tail   = 1'b0;

	two_class_priority_fifo_with_promotion DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apply_queue_op(input tcpf_pkg::in_t op);
		tcpf_pkg::out_t want;
		want = '0;
		want.status = tcpf_pkg::STS_DONE;
		case (op.operation)
			tcpf_pkg::OP_PUSH: begin
				if (normal_tasks.size() + urgent_tasks.size() >= tcpf_pkg::DEPTH) begin
					want.status = tcpf_pkg::STS_FULL;
				end else if (op.push_urgent) begin
					urgent_tasks.push_back(op.push_payload);
				end else begin
					normal_tasks.push_back(op.push_payload);
				end
			end
			tcpf_pkg::OP_POP: begin
				if (urgent_tasks.size() > 0) begin
					want.pop_payload = urgent_tasks.pop_front();
					want.pop_from_urgent = 1'b1;
				end else if (normal_tasks.size() > 0) begin
					want.pop_payload = normal_tasks.pop_front();
				end else begin
					want.status = tcpf_pkg::STS_EMPTY;
				end
			end
			tcpf_pkg::OP_PROMOTE: begin
				if (normal_tasks.size() > 0) begin
					urgent_tasks.push_back(normal_tasks.pop_front());
				end else begin
					want.status = tcpf_pkg::STS_NOTHING;
				end
			end
			default: begin
			end
		endcase
		want.normal_level = tcpf_pkg::LVL_W'(normal_tasks.size());
		want.urgent_level = tcpf_pkg::LVL_W'(urgent_tasks.size());
		due_results.push_back(want);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t: result %0d, %s: got %0h, expected %0h",
				$time, results_seen, what, got, want);
		end
		mismatches++;
	endtask

	task automatic check_result(input tcpf_pkg::out_t got);
		tcpf_pkg::out_t want;
		if (due_results.size() == 0) begin
			report_mismatch("transfer with nothing expected", 64'(got), 64'd0);
		end else begin
			want = due_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.pop_payload !== want.pop_payload)
				report_mismatch("pop_payload", 64'(got.pop_payload), 64'(want.pop_payload));
			if (got.pop_from_urgent !== want.pop_from_urgent)
				report_mismatch("pop_from_urgent", 64'(got.pop_from_urgent),
					64'(want.pop_from_urgent));
			if (got.normal_level !== want.normal_level)
				report_mismatch("normal_level", 64'(got.normal_level), 64'(want.normal_level));
			if (got.urgent_level !== want.urgent_level)
				report_mismatch("urgent_level", 64'(got.urgent_level), 64'(want.urgent_level));
		end
		results_seen++;
	endtask

	function automatic logic [tcpf_pkg::PAYLOAD_BITS-1:0] random_task();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return raw[tcpf_pkg::PAYLOAD_BITS-1:0];
		endcase
	endfunction

	function automatic void queue_op(input logic [tcpf_pkg::OP_W-1:0] code,
			input logic urgent, input logic [tcpf_pkg::PAYLOAD_BITS-1:0] payload,
			input bit drain_first);
		pending_op_t item;
		item.op.operation    = code;
		item.op.push_urgent  = urgent;
		item.op.push_payload = payload;
		item.wait_drain      = drain_first;
		op_backlog.push_back(item);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			quiet_tail <= (op_backlog.size() < TAIL_ITEMS);
			if (in_valid && in_ready)
				apply_queue_op(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (op_backlog.size() > 0 &&
						(!op_backlog[0].wait_drain || due_results.size() == 0)) begin
					next_op = op_backlog.pop_front();
					in_data <= next_op.op;
					in_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int push_pct;
		int urgent_pct;
		int segment_left;
		int pick;
		logic [tcpf_pkg::OP_W-1:0] code;

		// Both queues empty: refusals, ignored fields held high, unused code.
		queue_op(tcpf_pkg::OP_POP, 1'b1, '1, 1'b0);
		queue_op(tcpf_pkg::OP_PROMOTE, 1'b1, '1, 1'b0);
		queue_op(OP_SPARE, 1'b1, '1, 1'b0);
		// Promotion puts the older normal task behind the urgent one.
		queue_op(tcpf_pkg::OP_PUSH, 1'b0, '1, 1'b0);
		queue_op(tcpf_pkg::OP_PUSH, 1'b1, '0, 1'b0);
		queue_op(tcpf_pkg::OP_PROMOTE, 1'b0, random_task(), 1'b0);
		queue_op(tcpf_pkg::OP_POP, 1'b0, '0, 1'b0);
		queue_op(tcpf_pkg::OP_POP, 1'b0, '0, 1'b0);
		// Fill the shared capacity, then push, promote and idle at full.
		for (int i = 0; i <= tcpf_pkg::DEPTH; i++)
			queue_op(tcpf_pkg::OP_PUSH, i[0], random_task(), 1'b0);
		queue_op(tcpf_pkg::OP_PROMOTE, 1'b1, random_task(), 1'b0);
		queue_op(OP_SPARE, 1'b0, '0, 1'b0);

		push_pct = 50;
		urgent_pct = 50;
		segment_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (segment_left == 0) begin
				segment_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
				urgent_pct = 5 + 45 * $urandom_range(0, 2);
			end
			segment_left--;
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				code = tcpf_pkg::OP_PUSH;
			else if (pick >= 97)
				code = OP_SPARE;
			else if ($urandom_range(0, 2) == 0)
				code = tcpf_pkg::OP_PROMOTE;
			else
				code = tcpf_pkg::OP_POP;
			queue_op(code, $urandom_range(0, 99) < urgent_pct, random_task(),
				i == 0 || i == RANDOM_ITEMS / 2);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tcpf_pkg.sv
rtl/tcpf_ctrl.sv
rtl/tcpf_dp.sv
rtl/two_class_priority_fifo_with_promotion.sv
sim/two_class_priority_fifo_with_promotion_tb.sv
